/* hdl/hssd_pkg.sv */
`default_nettype none

package hssd_pkg;

    // Field widths of the channels and registers.
    localparam int INDEX_W = 8;
    localparam int CODE_W  = 10;
    localparam int DAC_W   = 17;
    localparam int MASK_W  = 4;
    localparam int AMP_W   = 10;

    // Waveform geometry. The period is a power of two so the phase wraps by truncation.
    localparam int SAMPLES_PER_PERIOD = 256;
    localparam int SINE_FRACTION_BITS = 15;
    localparam int PHASE_W            = $clog2(SAMPLES_PER_PERIOD);
    localparam int QUARTER            = SAMPLES_PER_PERIOD / 4;
    localparam int ADDR_W             = PHASE_W - 1;
    localparam int HARMONICS          = MASK_W;

    // Sine magnitude runs 0 .. 2^F, the signed value one bit wider.
    localparam int SINE_MAG_W = SINE_FRACTION_BITS + 1;
    localparam int SINE_W     = SINE_FRACTION_BITS + 2;
    localparam int SUM_W      = SINE_W + 3;
    localparam int CNT_W      = $clog2(HARMONICS + 1);
    localparam int NUM_W      = SINE_FRACTION_BITS + 4;
    localparam int PROD_W     = NUM_W + AMP_W;
    localparam int QUOT_W     = PROD_W - SINE_FRACTION_BITS - 1;

    // Exact division by three for quotients below 2^DIV3_SHIFT.
    localparam int DIV3_SHIFT = 17;
    localparam int DIV3_MUL_W = DIV3_SHIFT - 1;
    localparam int DIV3_MUL   = (2 ** DIV3_SHIFT + 2) / 3;
    localparam int DIV3_PROD_W = QUOT_W + DIV3_MUL_W;

    localparam logic [CODE_W-1:0] CODE_MAX = '1;
    localparam logic [AMP_W-1:0]  AMP_RESET = '1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HARMONIC_MASK = 1'b0,
        CFG_AMPLITUDE     = 1'b1
    } cfg_reg_t;

    typedef logic signed [SINE_W-1:0] sine_t;
    typedef logic [QUARTER:0][SINE_MAG_W-1:0] sine_tab_t;

    // Status of the sine lookup stage as seen by the summing stage.
    typedef struct packed {
        logic                  valid;
        logic [HARMONICS-1:0]  en;
        logic [HARMONICS-1:0][SINE_W-1:0] sine;
    } sine_bank_t;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Quarter-wave sine magnitudes in Q(F), built at elaboration from a
    // Taylor series in Horner form on a Q30 angle.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] term;
        for (int j = 0; j <= QUARTER; j++)
        begin
            x    = (PI_HALF_Q30 * 64'(4 * j)) / 64'(SAMPLES_PER_PERIOD);
            x2   = (x * x) >> 30;
            t    = Q30_ONE;
            term = ((x2 * t) >> 30) / 64'd110;
            t    = (term >= Q30_ONE) ? 64'd0 : (Q30_ONE - term);
            term = ((x2 * t) >> 30) / 64'd72;
            t    = (term >= Q30_ONE) ? 64'd0 : (Q30_ONE - term);
            term = ((x2 * t) >> 30) / 64'd42;
            t    = (term >= Q30_ONE) ? 64'd0 : (Q30_ONE - term);
            term = ((x2 * t) >> 30) / 64'd20;
            t    = (term >= Q30_ONE) ? 64'd0 : (Q30_ONE - term);
            term = ((x2 * t) >> 30) / 64'd6;
            t    = (term >= Q30_ONE) ? 64'd0 : (Q30_ONE - term);
            s    = (x * t) >> 30;
            if (s > Q30_ONE)
            begin
                s = Q30_ONE;
            end
            s = (s + (64'd1 << (29 - SINE_FRACTION_BITS))) >> (30 - SINE_FRACTION_BITS);
            if (s > (64'd1 << SINE_FRACTION_BITS))
            begin
                s = 64'd1 << SINE_FRACTION_BITS;
            end
            tab[j] = SINE_MAG_W'(s);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

/* hdl/hssd_if.sv */
`default_nettype none

// Channel that carries sample positions into the generator.
interface hssd_index_if;
    logic                          valid;
    logic                          ready;
    logic [hssd_pkg::INDEX_W-1:0]  sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

// Channel that carries generated codes to the converter.
interface hssd_sample_if;
    logic                         valid;
    logic                         ready;
    logic [hssd_pkg::CODE_W-1:0]  sample_code;
    logic [hssd_pkg::DAC_W-1:0]   dac_word;

    modport source (output valid, output sample_code, output dac_word, input ready);
    modport sink   (input valid, input sample_code, input dac_word, output ready);
endinterface

`default_nettype wire

/* hdl/hssd_sine_bank.sv */
`default_nettype none

// Looks up the signed sine of every harmonic for one sample position and
// registers the results. Disabled harmonics read as zero.
module hssd_sine_bank (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_valid,
    input  wire logic [hssd_pkg::PHASE_W-1:0]        idx,
    input  wire logic [hssd_pkg::HARMONICS-1:0]      mask,
    output hssd_pkg::sine_bank_t                     bank
);

    hssd_pkg::sine_bank_t bank_reg;
    hssd_pkg::sine_bank_t bank_next;

    always_comb
    begin
        logic [hssd_pkg::PHASE_W-1:0]    phase;
        logic [hssd_pkg::ADDR_W-1:0]     addr;
        logic [hssd_pkg::SINE_MAG_W-1:0] mag;
        hssd_pkg::sine_t                 val;
        bank_next       = bank_reg;
        bank_next.valid = in_valid;
        bank_next.en    = mask;
        for (int k = 0; k < hssd_pkg::HARMONICS; k++)
        begin
            // Harmonic 2^k advances the phase 2^k times as fast; the wrap is free.
            phase = hssd_pkg::PHASE_W'(idx << k);
            addr  = hssd_pkg::ADDR_W'(phase[hssd_pkg::PHASE_W-3:0]);
            if (phase[hssd_pkg::PHASE_W-2])
            begin
                addr = hssd_pkg::ADDR_W'(hssd_pkg::QUARTER) - addr;
            end
            mag = hssd_pkg::SINE_TAB[addr];
            val = hssd_pkg::sine_t'({1'b0, mag});
            if (phase[hssd_pkg::PHASE_W-1])
            begin
                val = -val;
            end
            bank_next.sine[k] = mask[k] ? val : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            bank_reg <= bank_next;
        end
    end

    assign bank = bank_reg;

endmodule

`default_nettype wire

/* hdl/harmonic_sine_sum_dac_sample_core.sv */
`default_nettype none

// Harmonic sine sum sample generator.
// A request on idx_ch carries a sample position within one period of the
// fundamental. For every request the block returns one result on smp_ch: the
// 10-bit converter code and the 17-bit DAC word (code in bits 15:6, bias bit 16).
// The code is the average of the enabled harmonics (1, 2, 4 and 8 times the
// fundamental), offset to unipolar and scaled by the amplitude register. With no
// harmonic enabled the code is midscale, half the amplitude.
// Registers are written through cfg_we, cfg_index and cfg_wdata and should only
// change while no request is in flight.
// Throughput is one request per cycle unless the receiver stalls smp_ch. On its
// way to smp_ch a request passes each register stage in turn: the input register
// loads at the accepting edge, then the sine lookup, the sum, the amplitude
// multiply and the final divide by the harmonic count each add one register stage.
// The whole pipeline advances together. When the receiver holds smp_ch.ready low
// with a result waiting, idx_ch.ready drops in the same cycle and every stage
// holds its contents, so nothing is lost or repeated; bubbles ahead of the last
// stage keep flowing while its register is empty.
// Reset clears all valid bits, sets the harmonic mask to zero and the amplitude
// to full scale. No clearing pass is needed.
module harmonic_sine_sum_dac_sample_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [hssd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hssd_pkg::AMP_W-1:0]       cfg_wdata,
    hssd_index_if.sink                            idx_ch,
    hssd_sample_if.source                         smp_ch
);

    // Configuration registers.
    logic [hssd_pkg::MASK_W-1:0] mask_reg;
    logic [hssd_pkg::AMP_W-1:0]  amp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            amp_reg  <= hssd_pkg::AMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hssd_pkg::CFG_HARMONIC_MASK: mask_reg <= cfg_wdata[hssd_pkg::MASK_W-1:0];
                hssd_pkg::CFG_AMPLITUDE:     amp_reg  <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    // One enable moves every stage; it is low only while a finished result is
    // waiting and the receiver is not taking it.
    logic adv;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || smp_ch.ready;
    assign idx_ch.ready = adv;

    // Stage 1: input register. The sample position wraps to one period here.
    logic                          s1_valid_reg;
    logic [hssd_pkg::PHASE_W-1:0]  s1_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= idx_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg <= hssd_pkg::PHASE_W'(idx_ch.sample_index);
        end
    end

    // Stage 2: sine lookup of all four harmonics in parallel.
    hssd_pkg::sine_bank_t bank;

    hssd_sine_bank u_sine_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s1_valid_reg),
        .idx      (s1_idx_reg),
        .mask     (mask_reg),
        .bank     (bank)
    );

    // Stage 3: sum of the enabled sines, offset by the count so that the value
    // is never negative. It ranges 0 .. 2 * count * 2^F.
    logic                          s3_valid_reg;
    logic [hssd_pkg::NUM_W-1:0]    s3_num_reg;
    logic [hssd_pkg::NUM_W-1:0]    s3_num_next;
    logic [hssd_pkg::CNT_W-1:0]    s3_cnt_reg;
    logic [hssd_pkg::CNT_W-1:0]    s3_cnt_next;

    always_comb
    begin
        logic signed [hssd_pkg::SUM_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < hssd_pkg::HARMONICS; k++)
        begin
            sum = sum + hssd_pkg::SUM_W'($signed(bank.sine[k]));
        end
        s3_cnt_next = hssd_pkg::CNT_W'($countones(bank.en));
        sum         = sum + (hssd_pkg::SUM_W'(s3_cnt_next) << hssd_pkg::SINE_FRACTION_BITS);
        s3_num_next = hssd_pkg::NUM_W'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= bank.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_num_reg <= s3_num_next;
            s3_cnt_reg <= s3_cnt_next;
        end
    end

    // Stage 4: scale by the amplitude.
    logic                          s4_valid_reg;
    logic [hssd_pkg::PROD_W-1:0]   s4_prod_reg;
    logic [hssd_pkg::CNT_W-1:0]    s4_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_prod_reg <= hssd_pkg::PROD_W'(s3_num_reg) * hssd_pkg::PROD_W'(amp_reg);
            s4_cnt_reg  <= s3_cnt_reg;
        end
    end

    // Stage 5: divide by 2 * count * 2^F. The power of two is a shift; the
    // remaining divide by the count is a shift, or a reciprocal multiply for three.
    logic [hssd_pkg::QUOT_W-1:0]      quot_base;
    logic [hssd_pkg::DIV3_PROD_W-1:0] div3_prod;
    logic [hssd_pkg::QUOT_W-1:0]      quot;
    logic [hssd_pkg::CODE_W-1:0]      code_next;
    logic [hssd_pkg::CODE_W-1:0]      code_reg;

    assign quot_base = hssd_pkg::QUOT_W'(s4_prod_reg >> (hssd_pkg::SINE_FRACTION_BITS + 1));
    assign div3_prod = hssd_pkg::DIV3_PROD_W'(quot_base)
                     * hssd_pkg::DIV3_PROD_W'(hssd_pkg::DIV3_MUL);

    always_comb
    begin
        case (s4_cnt_reg)
            hssd_pkg::CNT_W'(1): quot = quot_base;
            hssd_pkg::CNT_W'(2): quot = quot_base >> 1;
            hssd_pkg::CNT_W'(3): quot = hssd_pkg::QUOT_W'(div3_prod >> hssd_pkg::DIV3_SHIFT);
            hssd_pkg::CNT_W'(4): quot = quot_base >> 2;
            // No harmonic enabled: midscale.
            default:             quot = hssd_pkg::QUOT_W'(amp_reg >> 1);
        endcase
        if (quot > hssd_pkg::QUOT_W'(hssd_pkg::CODE_MAX))
        begin
            code_next = hssd_pkg::CODE_MAX;
        end
        else
        begin
            code_next = hssd_pkg::CODE_W'(quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg <= code_next;
        end
    end

    assign smp_ch.valid       = out_valid_reg;
    assign smp_ch.sample_code = code_reg;
    assign smp_ch.dac_word    = {1'b1, code_reg, 6'b0};

`ifndef SYNTHESIS
    // A waiting result that the receiver does not take must hold off new requests.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !smp_ch.ready |-> !idx_ch.ready)
        else $error("request accepted while the output is stalled");

    // An accepted request lands in the input stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        idx_ch.valid && idx_ch.ready |=> s1_valid_reg)
        else $error("accepted request did not enter the pipeline");

    // The offset sum never exceeds twice the enabled count in full-scale units.
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_num_reg <= (hssd_pkg::NUM_W'(s3_cnt_reg)
                                         << (hssd_pkg::SINE_FRACTION_BITS + 1)))
        else $error("harmonic sum out of range");

    // A stall freezes the last stage's code.
    a_stall_holds_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !smp_ch.ready |=> out_valid_reg && $stable(code_reg))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

// Bench for the harmonic sine sum sample generator.
// Sample positions are fed through a pending queue to a clocked driver. Every
// accepted request is run through a bit-exact predictor that builds the sine
// values with its own Q30 Taylor evaluation, averages the enabled harmonics and
// scales by the amplitude. The monitor checks each result against the oldest
// prediction. The register settings are changed only while the pipeline is
// empty, and the handshakes are stalled at random on both sides.
module tb;

    // One generated sample as seen on the output channel.
    typedef struct {
        logic [hssd_pkg::CODE_W-1:0] code;
        logic [hssd_pkg::DAC_W-1:0]  dac;
    } sample_t;

    localparam int           CLK_HALF      = 4;
    localparam int           RESET_CYCLES  = 6;
    localparam int           DRAIN_CYCLES  = 8;
    localparam int           QUIET_LIMIT   = 5000;
    localparam int           RANDOM_PHASES = 16;
    localparam int           PHASE_ITEMS   = 38;
    localparam longint       ONE_Q15       = longint'(1) << hssd_pkg::SINE_FRACTION_BITS;
    localparam longint       ANGLE_ONE     = longint'(1) << 30;
    localparam longint       QUARTER_ANGLE = 64'd1686629713;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [hssd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hssd_pkg::AMP_W-1:0]     cfg_wdata;

    hssd_index_if  idx_ch();
    hssd_sample_if smp_ch();

    harmonic_sine_sum_dac_sample_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .idx_ch    (idx_ch),
        .smp_ch    (smp_ch)
    );

    // The bench's own copy of the two registers, as they stand after reset.
    logic [hssd_pkg::MASK_W-1:0] mask_setting = '0;
    logic [hssd_pkg::AMP_W-1:0]  amp_setting  = '1;

    logic [hssd_pkg::INDEX_W-1:0] pending_indices[$];
    sample_t                      expected_samples[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int settings_used = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Signed Q15 sine of a phase within one period. The phase is folded into
    // the first quadrant, the angle is put in Q30 and the Taylor series is
    // evaluated innermost term first, each step truncating as the hardware
    // table generator does.
    function automatic longint sine_q15(input logic [hssd_pkg::INDEX_W-1:0] phase);
        int unsigned     divisors[5] = '{110, 72, 42, 20, 6};
        logic [1:0]      quadrant;
        longint unsigned pos;
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned mag;
        quadrant = phase[hssd_pkg::INDEX_W-1 -: 2];
        pos      = longint'(phase[hssd_pkg::INDEX_W-3:0]) * 4;
        if (quadrant[0])
        begin
            pos = hssd_pkg::SAMPLES_PER_PERIOD - pos;
        end
        angle    = (QUARTER_ANGLE * pos) / hssd_pkg::SAMPLES_PER_PERIOD;
        angle_sq = (angle * angle) >> 30;
        acc      = ANGLE_ONE;
        foreach (divisors[k])
        begin
            term = ((angle_sq * acc) >> 30) / divisors[k];
            acc  = (term >= ANGLE_ONE) ? 0 : ANGLE_ONE - term;
        end
        mag = (angle * acc) >> 30;
        if (mag > ANGLE_ONE)
        begin
            mag = ANGLE_ONE;
        end
        // Round from Q30 down to Q15 and keep the peak at exactly one.
        mag = (mag + (longint'(1) << (29 - hssd_pkg::SINE_FRACTION_BITS)))
              >> (30 - hssd_pkg::SINE_FRACTION_BITS);
        if (mag > ONE_Q15)
        begin
            mag = ONE_Q15;
        end
        return quadrant[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // Expected code and DAC word for one sample position under the current
    // register settings. Harmonic 2^k reads the phase k bits further on, and
    // the 8-bit phase wraps by itself. With no harmonic enabled the output
    // sits at half the amplitude.
    function automatic sample_t predict_sample(input logic [hssd_pkg::INDEX_W-1:0] position);
        sample_t                      result;
        logic [hssd_pkg::INDEX_W-1:0] phase;
        longint                       total;
        longint                       enabled;
        longint                       code;
        total   = 0;
        enabled = 0;
        for (int k = 0; k < hssd_pkg::HARMONICS; k++)
        begin
            if (mask_setting[k])
            begin
                phase   = position << k;
                total   += sine_q15(phase);
                enabled += 1;
            end
        end
        if (enabled == 0)
        begin
            code = amp_setting >> 1;
        end
        else
        begin
            // Offset the sum to unipolar, scale, then divide by twice the count
            // in one step so no precision is lost before the final floor.
            code = ((total + enabled * ONE_Q15) * longint'(amp_setting))
                   / (2 * enabled * ONE_Q15);
        end
        if (code > 1023)
        begin
            code = 1023;
        end
        result.code = hssd_pkg::CODE_W'(code);
        result.dac  = {1'b1, result.code, 6'b0};
        return result;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // The register port has no handshake: one cycle with the enable high.
    task automatic write_register(input hssd_pkg::cfg_reg_t which,
                                  input logic [hssd_pkg::AMP_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == hssd_pkg::CFG_HARMONIC_MASK)
        begin
            mask_setting = value[hssd_pkg::MASK_W-1:0];
        end
        else
        begin
            amp_setting = value;
        end
    endtask

    // Mask writes carry random upper bits, which the block must drop.
    task automatic apply_setting(input logic [hssd_pkg::MASK_W-1:0] mask,
                                 input logic [hssd_pkg::AMP_W-1:0] amp);
        logic [hssd_pkg::AMP_W-1:0] mask_word;
        mask_word = hssd_pkg::AMP_W'($urandom);
        mask_word[hssd_pkg::MASK_W-1:0] = mask;
        write_register(hssd_pkg::CFG_HARMONIC_MASK, mask_word);
        write_register(hssd_pkg::CFG_AMPLITUDE, amp);
        settings_used++;
    endtask

    // Hold the sender until the queue is empty, the last request is taken and
    // every expected sample has come back, then let the pipeline settle. The
    // check runs at the falling edge, where the handshake of the last rising
    // edge has fully settled.
    task automatic wait_for_empty_pipeline();
        do
        begin
            @(negedge clk);
        end
        while (pending_indices.size() != 0 || idx_ch.valid || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Driver: a new request is offered once the current one has been taken.
    // While idle the position lines carry noise the block must ignore.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (idx_ch.valid && idx_ch.ready)
            begin
                expected_samples.push_back(predict_sample(idx_ch.sample_index));
                requests_sent++;
            end
            if (!idx_ch.valid || idx_ch.ready)
            begin
                if (pending_indices.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    idx_ch.valid        <= 1'b1;
                    idx_ch.sample_index <= pending_indices.pop_front();
                end
                else
                begin
                    idx_ch.valid        <= 1'b0;
                    idx_ch.sample_index <= hssd_pkg::INDEX_W'($urandom);
                end
            end
        end
    end

    // Monitor: every accepted sample is checked against the oldest prediction.
    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n)
        begin
            if (smp_ch.valid && smp_ch.ready)
            begin
                results_seen++;
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] sample with no request outstanding: code %0d, dac %0h",
                                 $time, smp_ch.sample_code, smp_ch.dac_word);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (smp_ch.sample_code !== want.code)
                    begin
                        report_mismatch("sample_code", want.code, smp_ch.sample_code);
                    end
                    if (smp_ch.dac_word !== want.dac)
                    begin
                        report_mismatch("dac_word", want.dac, smp_ch.dac_word);
                    end
                end
            end
            smp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: too long without any request or sample moving means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((idx_ch.valid && idx_ch.ready) || (smp_ch.valid && smp_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        logic [hssd_pkg::INDEX_W-1:0] start;
        logic [hssd_pkg::MASK_W-1:0]  mask;
        logic [hssd_pkg::AMP_W-1:0]   amp;
        int                           chunk;
        int                           queued;
        int                           directed_points[12] = '{0, 64, 128, 192, 255, 1,
                                                              32, 96, 160, 224, 16, 48};

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = hssd_pkg::CFG_HARMONIC_MASK;
        cfg_wdata           = '0;
        idx_ch.valid        = 1'b0;
        idx_ch.sample_index = '0;
        smp_ch.ready        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The sender is lightly loaded and the receiver stalls
        // a lot, so results back up through every stage.
        send_idle_pct = 32;
        recv_idle_pct = 85;

        // Straight out of reset no harmonic is enabled: midscale of full scale.
        pending_indices.push_back(8'd0);
        pending_indices.push_back(8'd255);
        wait_for_empty_pipeline();

        // All harmonics at full scale, over the quadrant boundaries and the
        // points where the higher harmonics peak and cross zero.
        apply_setting(4'hF, 10'd1023);
        foreach (directed_points[i])
        begin
            pending_indices.push_back(hssd_pkg::INDEX_W'(directed_points[i]));
        end
        wait_for_empty_pipeline();

        // Fundamental alone: positive peak hits the top code, negative peak zero.
        apply_setting(4'h1, 10'd1023);
        pending_indices.push_back(8'd64);
        pending_indices.push_back(8'd192);
        wait_for_empty_pipeline();

        // Zero amplitude forces every code to zero.
        apply_setting(4'h8, 10'd0);
        pending_indices.push_back(8'd0);
        pending_indices.push_back(8'd100);
        wait_for_empty_pipeline();

        // Smallest nonzero amplitude on the second harmonic.
        apply_setting(4'h2, 10'd1);
        pending_indices.push_back(8'd32);
        pending_indices.push_back(8'd96);
        pending_indices.push_back(8'd0);
        wait_for_empty_pipeline();

        // Random part. Each phase runs one register setting; the mask walks
        // through all sixteen values and the amplitude visits its extremes.
        // Positions come as buffer-fill ramps from a random start mixed with
        // scattered random positions.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 6)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 85;
            end
            else if (p < 12)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            mask = hssd_pkg::MASK_W'((p * 7) % 16);
            case (p % 4)
                0:       amp = 10'd1023;
                1:       amp = 10'd0;
                2:       amp = hssd_pkg::AMP_W'($urandom_range(1, 1022));
                default: amp = (p < 8) ? 10'd1 : 10'd512;
            endcase
            apply_setting(mask, amp);

            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                chunk = $urandom_range(1, 12);
                if (chunk > PHASE_ITEMS - queued)
                begin
                    chunk = PHASE_ITEMS - queued;
                end
                start = hssd_pkg::INDEX_W'($urandom);
                for (int i = 0; i < chunk; i++)
                begin
                    if ($urandom_range(1) == 0)
                    begin
                        pending_indices.push_back(start + hssd_pkg::INDEX_W'(i));
                    end
                    else
                    begin
                        pending_indices.push_back(hssd_pkg::INDEX_W'($urandom));
                    end
                end
                queued += chunk;
            end
            wait_for_empty_pipeline();
        end

        if (expected_samples.size() != 0)
        begin
            mismatches += expected_samples.size();
            $display("%0d expected samples never arrived", expected_samples.size());
        end

        $display("Ran %0d requests and checked %0d samples over %0d register settings,",
                 requests_sent, results_seen, settings_used);
        $display("covering all harmonic masks, zero and full amplitude, and stalls on both sides.");
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
